>>> src/asgr_pkg.sv
`timescale 1ns / 1ps

package asgr_pkg;

  // Grid geometry
  localparam int GRID_WIDTH  = 80;
  localparam int GRID_HEIGHT = 25;
  localparam int COL_W = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
  localparam int ROW_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

  // Field widths
  localparam int CHAR_W       = 8;
  localparam int COLOR_W      = 4;
  localparam int KIND_W       = 2;
  localparam int CELL_INDEX_W = 11;
  localparam int CELL_ENTRY_W = 16;
  localparam int CODE_W       = 8;
  localparam int CFG_INDEX_W  = 1;
  localparam int MAX_RESULTS  = 3;
  localparam int COUNT_W      = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_FOREGROUND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_BACKGROUND = 1'b1;

  localparam logic [COLOR_W-1:0] RESET_FOREGROUND_DEFAULT = 4'd7;
  localparam logic [COLOR_W-1:0] RESET_BACKGROUND_DEFAULT = 4'd0;

  // Byte codes
  localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_SGR_END  = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h00;

  // SGR codes
  localparam logic [CODE_W-1:0] SGR_RESET    = 8'd0;
  localparam logic [CODE_W-1:0] SGR_BOLD     = 8'd1;
  localparam logic [CODE_W-1:0] SGR_DIM      = 8'd2;
  localparam logic [CODE_W-1:0] SGR_BLINK    = 8'd5;
  localparam logic [CODE_W-1:0] SGR_REVERSE  = 8'd7;
  localparam logic [CODE_W-1:0] SGR_NORMAL   = 8'd22;
  localparam logic [CODE_W-1:0] SGR_FG_LO    = 8'd30;
  localparam logic [CODE_W-1:0] SGR_FG_HI    = 8'd37;
  localparam logic [CODE_W-1:0] SGR_BG_LO    = 8'd40;
  localparam logic [CODE_W-1:0] SGR_BG_HI    = 8'd47;
  localparam logic [CODE_W-1:0] SGR_FGB_LO   = 8'd90;
  localparam logic [CODE_W-1:0] SGR_FGB_HI   = 8'd97;
  localparam logic [CODE_W-1:0] SGR_BGB_LO   = 8'd100;
  localparam logic [CODE_W-1:0] SGR_BGB_HI   = 8'd107;
  localparam logic [CODE_W-1:0] CODE_MAX     = 8'd255;

  localparam logic [COLOR_W-1:0] BRIGHT_MASK = 4'b1000;
  localparam logic [COLOR_W-1:0] BASE_MASK   = 4'b0111;

  typedef enum logic [1:0] {
    PHASE_TEXT = 2'd0,
    PHASE_ESC  = 2'd1,
    PHASE_SGR  = 2'd2
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CELL   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CURSOR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [CELL_INDEX_W-1:0]  index;
    logic [CELL_ENTRY_W-1:0]  entry;
    logic                     last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] slot;
    logic [COUNT_W-1:0]        count;
  } bundle_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
  } colors_t;

  // ANSI color order to VGA attribute order
  function automatic logic [COLOR_W-1:0] color_map(input logic [2:0] ansi);
    logic [COLOR_W-1:0] c;
    unique case (ansi)
      3'd0: c = 4'h0;
      3'd1: c = 4'h4;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h1;
      3'd5: c = 4'h5;
      3'd6: c = 4'h3;
      default: c = 4'h7;
    endcase
    return c;
  endfunction

  function automatic colors_t apply_sgr(input logic [CODE_W-1:0] code,
                                        input colors_t cur,
                                        input colors_t rst_colors);
    colors_t r;
    logic [CODE_W-1:0] d;
    r = cur;
    d = '0;
    if (code == SGR_RESET) begin
      r = rst_colors;
    end else if (code == SGR_BOLD) begin
      r.fore = cur.fore | BRIGHT_MASK;
    end else if (code == SGR_DIM || code == SGR_NORMAL) begin
      r.fore = cur.fore & BASE_MASK;
    end else if (code == SGR_BLINK) begin
      r.back = cur.back | BRIGHT_MASK;
    end else if (code == SGR_REVERSE) begin
      r.fore = cur.back;
      r.back = cur.fore;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      d = code - SGR_FG_LO;
      r.fore = color_map(d[2:0]);
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      d = code - SGR_BG_LO;
      r.back = color_map(d[2:0]);
    end else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI) begin
      d = code - SGR_FGB_LO;
      r.fore = color_map(d[2:0]) | BRIGHT_MASK;
    end else if (code >= SGR_BGB_LO && code <= SGR_BGB_HI) begin
      d = code - SGR_BGB_LO;
      r.back = color_map(d[2:0]) | BRIGHT_MASK;
    end
    return r;
  endfunction

endpackage

>>> src/asgr_byte_if.sv
`timescale 1ns / 1ps

interface asgr_byte_if import asgr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

>>> src/asgr_result_if.sv
`timescale 1ns / 1ps

interface asgr_result_if import asgr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       result_kind;
  logic [CELL_INDEX_W-1:0] cell_index;
  logic [CELL_ENTRY_W-1:0] cell_entry;
  logic                    last_result;

  modport source (output valid, output result_kind, output cell_index,
                  output cell_entry, output last_result, input ready);
  modport sink   (input valid, input result_kind, input cell_index,
                  input cell_entry, input last_result, output ready);
endinterface

>>> src/ansi_sgr_text_console_writer_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                        | Transaction
// ---------+-----+------------------------------------------------+-----------------
// text     | in  | char_byte[7:0], end_of_string                  | valid && ready
// result   | out | result_kind[1:0], cell_index[10:0],            | valid && ready
//          |     | cell_entry[15:0], last_result                  |
// cfg      | in  | cfg_index, cfg_data[3:0]                       | cfg_we
//
// One byte per cycle when the result side keeps up. A byte causes zero to three
// results; they are loaded together into a three-slot result register that drains
// one per cycle while ready; the next byte waits until the last result is taken.
// Reset (rst, synchronous) clears cursor, parser and color state and the result
// queue. A stall on result blocks text whenever the queue holds a result.

module ansi_sgr_text_console_writer_top import asgr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  asgr_byte_if.sink              text,
  asgr_result_if.source          result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data
);

  localparam int IDX_CALC_W = (ROW_W + COL_W + 1 > CELL_INDEX_W) ?
                              ROW_W + COL_W + 1 : CELL_INDEX_W;

  // Configuration
  logic [COLOR_W-1:0] reset_foreground;
  logic [COLOR_W-1:0] reset_background;

  // Console state
  phase_t             phase, phase_next;
  logic [CODE_W-1:0]  code_acc, code_acc_next;
  colors_t            colors, colors_next;
  logic [ROW_W-1:0]   cursor_row, cursor_row_next;
  logic [COL_W-1:0]   cursor_column, cursor_column_next;

  logic    accept;
  logic    can_load;
  bundle_t bundle;

  assign text.ready = can_load;
  assign accept     = text.valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_foreground <= RESET_FOREGROUND_DEFAULT;
      reset_background <= RESET_BACKGROUND_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_FOREGROUND: reset_foreground <= cfg_data;
        REG_RESET_BACKGROUND: reset_background <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_TEXT;
      code_acc      <= '0;
      colors.fore   <= RESET_FOREGROUND_DEFAULT;
      colors.back   <= RESET_BACKGROUND_DEFAULT;
      cursor_row    <= '0;
      cursor_column <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      code_acc      <= code_acc_next;
      colors        <= colors_next;
      cursor_row    <= cursor_row_next;
      cursor_column <= cursor_column_next;
    end
  end

  // Per-byte decode: parser step, cursor motion, result bundle.
  always_comb begin
    logic [CHAR_W-1:0]     ch;
    logic                  put;
    logic [CHAR_W-1:0]     put_ch;
    logic                  do_scroll;
    logic                  wrap;
    logic [11:0]           acc_prod;
    logic [CHAR_W-1:0]     digit;
    logic [IDX_CALC_W-1:0] idx_here;
    logic [IDX_CALC_W-1:0] idx_next;
    logic [COUNT_W-1:0]    n;
    colors_t               rst_colors;

    ch          = text.char_byte;
    put         = 1'b0;
    put_ch      = ch;
    do_scroll   = 1'b0;
    wrap        = 1'b0;
    digit       = ch - CH_ZERO;
    acc_prod    = 12'(code_acc) * 12'd10 + 12'(digit);
    rst_colors.fore = reset_foreground;
    rst_colors.back = reset_background;

    phase_next         = phase;
    code_acc_next      = code_acc;
    colors_next        = colors;
    cursor_row_next    = cursor_row;
    cursor_column_next = cursor_column;

    unique case (phase)
      PHASE_SGR: begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          code_acc_next = (acc_prod > 12'(CODE_MAX)) ? CODE_MAX : acc_prod[CODE_W-1:0];
        end else if (ch == CH_SEMI) begin
          colors_next   = apply_sgr(code_acc, colors, rst_colors);
          code_acc_next = '0;
        end else begin
          // 'm' closes and applies; anything else just drops the sequence
          if (ch == CH_SGR_END) begin
            colors_next = apply_sgr(code_acc, colors, rst_colors);
          end
          code_acc_next = '0;
          phase_next    = PHASE_TEXT;
        end
      end
      PHASE_ESC: begin
        if (ch == CH_LBRACKET) begin
          phase_next    = PHASE_SGR;
          code_acc_next = '0;
        end else if (ch == CH_ESC) begin
          phase_next = PHASE_ESC;
        end else begin
          phase_next = PHASE_TEXT;
          put        = 1'b1;
        end
      end
      default: begin
        if (ch == CH_ESC) begin
          phase_next = PHASE_ESC;
        end else begin
          phase_next = PHASE_TEXT;
          put        = 1'b1;
        end
      end
    endcase

    // Newline stores a blank cell, then both newline and a full row wrap
    if (put) begin
      if (ch == CH_NEWLINE) begin
        put_ch = CH_BLANK;
        wrap   = 1'b1;
      end else begin
        wrap   = (cursor_column == COL_W'(GRID_WIDTH - 1));
      end
      if (wrap) begin
        cursor_column_next = '0;
        if (cursor_row == ROW_W'(GRID_HEIGHT - 1)) begin
          do_scroll = 1'b1;
        end else begin
          cursor_row_next = cursor_row + ROW_W'(1);
        end
      end else begin
        cursor_column_next = cursor_column + COL_W'(1);
      end
    end

    if (text.end_of_string) begin
      phase_next    = PHASE_TEXT;
      code_acc_next = '0;
    end

    idx_here = IDX_CALC_W'(cursor_row) * IDX_CALC_W'(GRID_WIDTH) + IDX_CALC_W'(cursor_column);
    idx_next = IDX_CALC_W'(cursor_row_next) * IDX_CALC_W'(GRID_WIDTH) +
               IDX_CALC_W'(cursor_column_next);

    // Pack results in order: cell write, scroll, cursor
    bundle = '0;
    n      = '0;
    if (put) begin
      bundle.slot[n].kind  = KIND_CELL;
      bundle.slot[n].index = idx_here[CELL_INDEX_W-1:0];
      bundle.slot[n].entry = {colors.back, colors.fore, put_ch};
      n = n + COUNT_W'(1);
    end
    if (do_scroll) begin
      bundle.slot[n].kind  = KIND_SCROLL;
      bundle.slot[n].index = '0;
      bundle.slot[n].entry = {colors.back, colors.fore, CH_BLANK};
      n = n + COUNT_W'(1);
    end
    if (text.end_of_string) begin
      bundle.slot[n].kind  = KIND_CURSOR;
      bundle.slot[n].index = idx_next[CELL_INDEX_W-1:0];
      bundle.slot[n].entry = '0;
      n = n + COUNT_W'(1);
    end
    unique case (n)
      COUNT_W'(1): bundle.slot[0].last = 1'b1;
      COUNT_W'(2): bundle.slot[1].last = 1'b1;
      COUNT_W'(3): bundle.slot[2].last = 1'b1;
      default: ;
    endcase
    bundle.count = n;
  end

  asgr_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .bundle   (bundle),
    .can_load (can_load),
    .result   (result)
  );

endmodule

>>> src/asgr_result_queue.sv
`timescale 1ns / 1ps

module asgr_result_queue import asgr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  bundle_t       bundle,
  output logic          can_load,
  asgr_result_if.source result
);

  result_t [MAX_RESULTS-1:0] slot;
  logic [COUNT_W-1:0]        count;
  logic                      pop;

  assign pop      = result.valid && result.ready;
  assign can_load = (count == '0) || (count == COUNT_W'(1) && result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= bundle.count;
    end else if (pop) begin
      count <= count - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= bundle.slot;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  assign result.valid       = (count != '0);
  assign result.result_kind = slot[0].kind;
  assign result.cell_index  = slot[0].index;
  assign result.cell_entry  = slot[0].entry;
  assign result.last_result = slot[0].last;

endmodule
